@@ rtl/fdcd_pkg.sv @@
// Shared constants, types and helpers of the frame-difference cut detector.
package fdcd_pkg;

   // Largest frame the store holds
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 1024;
   localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned POS_W  = $clog2(STORE_DEPTH);
   localparam int unsigned NPIX_W = POS_W + 1;

   // Field widths
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned PIX_W   = 3 * CHAN_W;
   localparam int unsigned DIM_W   = 11;
   localparam int unsigned THR_W   = 10;
   localparam int unsigned TGT_W   = 10;
   localparam int unsigned CNT_W   = TGT_W + 1;
   localparam int unsigned SEG_W   = 16;
   localparam int unsigned SUM_W   = 30;
   localparam int unsigned PDIFF_W = CHAN_W + 2;
   localparam int unsigned LIMIT_W = THR_W + NPIX_W;

   // Register reset values
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST   = DIM_W'(640);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST  = DIM_W'(480);
   localparam logic [THR_W-1:0] CUT_THRESHOLD_RST = THR_W'(100);
   localparam logic [TGT_W-1:0] TARGET_LENGTH_RST = TGT_W'(40);

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CUT_THRESHOLD = 2'd2,
      CSR_TARGET_LENGTH = 2'd3
   } csr_index_type;

   // Clamp a size register to 1..max
   function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Absolute difference of two channel values
   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ rtl/frame_difference_cut_detector.sv @@
// Top level of the frame-difference cut detector: frame store, accumulator, shot logic.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  req     | in        | req_valid/req_stall | req_pixel_blue/green/red
//  rsp     | out       | rsp_valid/rsp_stall | is_cut, keep_frame, shot_complete,
//          |           |                    | segment_index, difference_sum
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One pixel a cycle while the input side is not stalled; a pixel's result (at a frame's
// last pixel) passes stage 1, whose frame-store read is registered with the transfer,
// and stage 1 accumulates straight into the result register.
// The frame store has one write and one read port; the same pixel address read in the
// cycle it is written is served by a forwarding register.
// Synchronous active-high reset clears control state; the store is undefined until written.
// A last pixel waiting on a full, stalled result register holds the input side.
module frame_difference_cut_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fdcd_pkg::CHAN_W-1:0]   req_pixel_blue,
   input  logic [fdcd_pkg::CHAN_W-1:0]   req_pixel_green,
   input  logic [fdcd_pkg::CHAN_W-1:0]   req_pixel_red,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_cut,
   output logic                          rsp_keep_frame,
   output logic                          rsp_shot_complete,
   output logic [fdcd_pkg::SEG_W-1:0]    rsp_segment_index,
   output logic [fdcd_pkg::SUM_W-1:0]    rsp_difference_sum,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  fdcd_pkg::csr_index_type       csr_index,
   input  logic [fdcd_pkg::DIM_W-1:0]    csr_data
);
   import fdcd_pkg::*;

   // Configuration registers
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [THR_W-1:0] cut_threshold_ff;
   logic [TGT_W-1:0] target_length_ff;

   // Input side state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             first_ff, first_in;

   // Stage 1: pixel waiting for its stored neighbour
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [POS_W-1:0]  s1_pos_ff;
   logic              s1_last_ff, s1_first_ff;
   logic [NPIX_W-1:0] s1_npix_ff;

   // Frame store and read path
   logic [PIX_W-1:0] store_mem [STORE_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic             byp_ff;
   logic [PIX_W-1:0] byp_data_ff;

   // Accumulator and shot state
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SEG_W-1:0] seg_ff, seg_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             cut_ff, cut_in;
   logic             keep_ff, keep_in;
   logic             complete_ff, complete_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [DIM_W-1:0]   width_c, height_c;
   logic [NPIX_W-1:0]  npix;
   logic [NPIX_W-1:0]  pos_next;
   logic               is_last;
   logic               req_xfer, s1_adv, rsp_xfer;
   logic [PIX_W-1:0]   old_pix;
   logic [PDIFF_W-1:0] pix_diff;
   logic [SUM_W-1:0]   acc_sum;
   logic [LIMIT_W-1:0] limit;
   logic [CNT_W-1:0]   count_inc, count_cap;
   logic               cut_c;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         cut_threshold_ff <= CUT_THRESHOLD_RST;
         target_length_ff <= TARGET_LENGTH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data;
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data;
            CSR_CUT_THRESHOLD: cut_threshold_ff <= csr_data[THR_W-1:0];
            CSR_TARGET_LENGTH: target_length_ff <= csr_data[TGT_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame size and position of the incoming pixel
   assign width_c  = clamp_size(frame_width_ff, DIM_W'(MAX_WIDTH));
   assign height_c = clamp_size(frame_height_ff, DIM_W'(MAX_HEIGHT));
   assign npix     = NPIX_W'(width_c) * NPIX_W'(height_c);
   assign pos_next = NPIX_W'(pos_ff) + NPIX_W'(1);
   assign is_last  = (pos_next >= npix);

   // Handshakes: hold stage 1 only when a last pixel meets a stalled full result
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign s1_adv    = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      pos_in      = pos_ff;
      first_in    = first_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         pos_in      = is_last ? '0 : pos_next[POS_W-1:0];
         if (is_last) begin
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         first_ff    <= 1'b1;
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         first_ff    <= first_in;
         s1_valid_ff <= s1_valid_in;
         if (req_xfer) begin
            byp_ff <= s1_adv && (s1_pos_ff == pos_ff);
         end else if (s1_adv) begin
            byp_ff <= 1'b0;
         end
      end
   end

   // Stage 1 payload and forwarding data
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pix_ff   <= {req_pixel_red, req_pixel_green, req_pixel_blue};
         s1_pos_ff   <= pos_ff;
         s1_last_ff  <= is_last;
         s1_first_ff <= first_ff;
         s1_npix_ff  <= npix;
         byp_data_ff <= s1_pix_ff;
      end
   end

   // Frame store: read the old pixel on transfer, write the new one as stage 1 advances
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         store_mem[s1_pos_ff] <= s1_pix_ff;
      end
      if (req_xfer) begin
         rd_data_ff <= store_mem[pos_ff];
      end
   end

   // Difference, accumulation and shot bookkeeping
   assign old_pix  = byp_ff ? byp_data_ff : rd_data_ff;
   assign pix_diff = PDIFF_W'(abs_diff(s1_pix_ff[CHAN_W-1:0], old_pix[CHAN_W-1:0]))
                   + PDIFF_W'(abs_diff(s1_pix_ff[2*CHAN_W-1:CHAN_W],
                                       old_pix[2*CHAN_W-1:CHAN_W]))
                   + PDIFF_W'(abs_diff(s1_pix_ff[PIX_W-1:2*CHAN_W],
                                       old_pix[PIX_W-1:2*CHAN_W]));
   assign acc_sum   = s1_first_ff ? acc_ff : (acc_ff + SUM_W'(pix_diff));
   assign limit     = LIMIT_W'(cut_threshold_ff) * LIMIT_W'(s1_npix_ff);
   assign cut_c     = (LIMIT_W'(acc_sum) > limit);
   assign count_cap = CNT_W'(target_length_ff) + CNT_W'(1);
   assign count_inc = (count_ff + CNT_W'(1) > count_cap) ? count_cap
                                                         : count_ff + CNT_W'(1);

   always_comb begin
      acc_in       = acc_ff;
      count_in     = count_ff;
      seg_in       = seg_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      cut_in       = cut_ff;
      keep_in      = keep_ff;
      complete_in  = complete_ff;
      sum_in       = sum_ff;
      if (s1_adv) begin
         acc_in = acc_sum;
         if (s1_last_ff) begin
            acc_in       = '0;
            rsp_valid_in = 1'b1;
            if (s1_first_ff) begin
               cut_in      = 1'b0;
               keep_in     = 1'b1;
               complete_in = 1'b0;
               sum_in      = '0;
            end else begin
               sum_in      = acc_sum;
               cut_in      = cut_c;
               complete_in = 1'b0;
               count_in    = count_inc;
               if (cut_c) begin
                  complete_in = (count_inc == CNT_W'(target_length_ff));
                  if (count_inc == CNT_W'(target_length_ff)) begin
                     seg_in = seg_ff + SEG_W'(1);
                  end
                  count_in = '0;
               end
               keep_in = (count_in < CNT_W'(target_length_ff));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         count_ff     <= '0;
         seg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      cut_ff      <= cut_in;
      keep_ff     <= keep_in;
      complete_ff <= complete_in;
      sum_ff      <= sum_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_cut         = cut_ff;
   assign rsp_keep_frame     = keep_ff;
   assign rsp_shot_complete  = complete_ff;
   assign rsp_segment_index  = seg_ff;
   assign rsp_difference_sum = sum_ff;

`ifndef SYNTHESIS
   // Input side stalls only behind a held stage 1 pixel
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with stage 1 empty");

   // Forwarding only applies to a pixel that is in stage 1
   a_byp_with_s1: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> s1_valid_ff)
      else $error("forwarding flag set without a stage 1 pixel");

   // A completed shot is always closed by a cut
   a_complete_cut: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && complete_ff |-> cut_ff)
      else $error("shot complete without a cut");

   // Segment index moves by at most one per cycle
   a_seg_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (seg_ff == $past(seg_ff)) || (seg_ff == $past(seg_ff) + SEG_W'(1)))
      else $error("segment index jumped");

   // A result held under stall does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(sum_ff) && $stable(seg_ff))
      else $error("stalled result changed");
`endif

endmodule
